// ----- hw/rtl/tfv_pkg.sv -----
// Shared types and constants for the torus field value block.
// No dependencies; used by every module of the block.
package tfv_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int ABS_W           = 31;   // |t| after clamp to 2^31-1
  localparam int SQ_W            = 62;   // square of ABS_W bits
  localparam int FIELD_W         = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THICK_SQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIV   = 3'd5;

  localparam logic [63:0] ROW_RESET       = 64'd0;
  localparam logic [15:0] RADIUS_RESET    = 16'd256;
  localparam logic [31:0] THICK_SQ_RESET  = 32'd65536;
  localparam logic [15:0] MIN_DIV_RESET   = 16'd1;

  // squared torus-space coordinates handed from front to back
  typedef struct packed {
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
  } sq_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hw/rtl/tfv_front.sv -----
// Front end: affine transform into torus space, rounding, clamp and squaring.
// Depends on tfv_pkg.
module tfv_front #(
  parameter int COORD_WIDTH = tfv_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic [63:0]                   row_x,
  input  logic [63:0]                   row_y,
  input  logic [63:0]                   row_z,
  output logic                          out_valid,
  output tfv_pkg::sq_item_t             out_item
);

  localparam int PW    = COORD_WIDTH + 16;
  localparam int ACC_W = ((COORD_WIDTH + 18) > 29 ? (COORD_WIDTH + 18) : 29) + 1;
  localparam int RW    = ACC_W - 12;

  logic [63:0] rows [3];
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [PW-1:0] prod_nxt [3][3];
  logic [tfv_pkg::ABS_W-1:0] mag_r [3];
  logic [tfv_pkg::ABS_W-1:0] mag_nxt [3];
  logic [tfv_pkg::SQ_W-1:0] sq_r [3];
  logic v1_r, v2_r, v3_r;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_nxt[r][0] = pos_x * $signed(rows[r][15:0]);
      prod_nxt[r][1] = pos_y * $signed(rows[r][31:16]);
      prod_nxt[r][2] = pos_z * $signed(rows[r][47:32]);
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [RW-1:0]    rnd;
    logic [63:0]             r64;
    logic [63:0]             mag;
    for (int r = 0; r < 3; r++) begin
      acc = {{(ACC_W-PW){prod_r[r][0][PW-1]}}, prod_r[r][0]}
          + {{(ACC_W-PW){prod_r[r][1][PW-1]}}, prod_r[r][1]}
          + {{(ACC_W-PW){prod_r[r][2][PW-1]}}, prod_r[r][2]}
          + {{(ACC_W-28){rows[r][63]}}, rows[r][63:48], 12'd0}
          + ACC_W'(2048);
      rnd = acc[ACC_W-1:12];   // floor after adding half: round half up
      r64 = {{(64-RW){rnd[RW-1]}}, rnd};
      mag = r64[63] ? (64'd0 - r64) : r64;
      // clamp at +-(2^31-1) only matters through the magnitude
      mag_nxt[r] = (mag > 64'h7FFF_FFFF) ? {tfv_pkg::ABS_W{1'b1}}
                                         : mag[tfv_pkg::ABS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    prod_r <= prod_nxt;
    mag_r  <= mag_nxt;
    for (int r = 0; r < 3; r++) begin
      sq_r[r] <= mag_r[r] * mag_r[r];
    end
  end

  assign out_valid     = v3_r;
  assign out_item.sq_x = sq_r[0];
  assign out_item.sq_y = sq_r[1];
  assign out_item.sq_z = sq_r[2];

endmodule

// ----- hw/rtl/tfv_queue.sv -----
// Two-entry queue between front and back ends.
// Depends on tfv_pkg.
module tfv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tfv_pkg::sq_item_t push_item,
  input  logic              pop,
  output tfv_pkg::sq_item_t pop_item,
  output tfv_pkg::q_stat_t  stat
);

  tfv_pkg::sq_item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_pop, do_push;

  assign do_pop  = pop && (count_r != 2'd0);
  assign do_push = push && (count_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

// ----- hw/rtl/tfv_back.sv -----
// Back end: pipelined square root, ring distance, denominator and divider.
// Depends on tfv_pkg.
module tfv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tfv_pkg::sq_item_t           in_item,
  input  logic [15:0]                 radius,
  input  logic [31:0]                 thick_sq,
  input  logic [15:0]                 min_div,
  output logic                        out_valid,
  output logic [tfv_pkg::FIELD_W-1:0] out_field,
  output logic                        out_sat
);

  localparam int RT_STEPS = 32;
  localparam int DV_STEPS = tfv_pkg::FIELD_W;

  // root pipeline, one root bit per stage; stage 0 holds the planar sum
  logic [63:0] rt_n   [RT_STEPS+1];
  logic [33:0] rt_rem [RT_STEPS+1];
  logic [31:0] rt_root[RT_STEPS+1];
  logic [tfv_pkg::SQ_W-1:0] rt_tz [RT_STEPS+1];
  logic        rt_v   [RT_STEPS+1];
  logic [63:0] rt_n_nxt   [RT_STEPS];
  logic [33:0] rt_rem_nxt [RT_STEPS];
  logic [31:0] rt_root_nxt[RT_STEPS];
  logic [62:0] sum_nxt;

  // distance square
  logic [63:0]             d2_r;
  logic [tfv_pkg::SQ_W-1:0] tzd_r;
  logic                    vd_r;

  // divider, one quotient bit per stage; stage 0 holds the denominator
  logic [63:0] dv_rem [DV_STEPS+1];
  logic [63:0] dv_den [DV_STEPS+1];
  logic [31:0] dv_q   [DV_STEPS+1];
  logic        dv_sat [DV_STEPS+1];
  logic        dv_v   [DV_STEPS+1];
  logic [63:0] dv_rem_nxt [DV_STEPS];
  logic [31:0] dv_q_nxt   [DV_STEPS];
  logic [31:0] num_low;

  logic [32:0] d_nxt;
  logic [31:0] dmag_nxt;
  logic [64:0] s1_nxt, s2_nxt;
  logic [63:0] s1c_nxt, den_nxt;

  assign num_low = {thick_sq[15:0], 16'd0};
  assign sum_nxt = {1'b0, in_item.sq_x} + {1'b0, in_item.sq_y};

  always_comb begin
    logic [35:0] rem_sh;
    logic [35:0] trial;
    for (int k = 0; k < RT_STEPS; k++) begin
      rem_sh = {rt_rem[k], rt_n[k][63:62]};
      trial  = {2'b00, rt_root[k], 2'b01};
      rt_n_nxt[k] = {rt_n[k][61:0], 2'b00};
      if (rem_sh >= trial) begin
        rt_rem_nxt[k]  = 34'(rem_sh - trial);
        rt_root_nxt[k] = {rt_root[k][30:0], 1'b1};
      end else begin
        rt_rem_nxt[k]  = rem_sh[33:0];
        rt_root_nxt[k] = {rt_root[k][30:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [64:0] rsh;
    for (int j = 0; j < DV_STEPS; j++) begin
      rsh = {dv_rem[j], num_low[DV_STEPS-1-j]};
      if (rsh >= {1'b0, dv_den[j]}) begin
        dv_rem_nxt[j] = 64'(rsh - {1'b0, dv_den[j]});
        dv_q_nxt[j]   = {dv_q[j][30:0], 1'b1};
      end else begin
        dv_rem_nxt[j] = rsh[63:0];
        dv_q_nxt[j]   = {dv_q[j][30:0], 1'b0};
      end
    end
  end

  always_comb begin
    d_nxt    = {1'b0, rt_root[RT_STEPS]} - {17'd0, radius};
    dmag_nxt = d_nxt[32] ? 32'(33'd0 - d_nxt) : d_nxt[31:0];
    // saturating adds at 2^64-1
    s1_nxt   = {1'b0, d2_r} + {3'd0, tzd_r};
    s1c_nxt  = s1_nxt[64] ? {64{1'b1}} : s1_nxt[63:0];
    s2_nxt   = {1'b0, s1c_nxt} + {49'd0, min_div};
    den_nxt  = s2_nxt[64] ? {64{1'b1}} : s2_nxt[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= RT_STEPS; k++) rt_v[k] <= 1'b0;
      vd_r <= 1'b0;
      for (int j = 0; j <= DV_STEPS; j++) dv_v[j] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rt_v[0] <= in_valid;
      for (int k = 1; k <= RT_STEPS; k++) rt_v[k] <= rt_v[k-1];
      vd_r <= rt_v[RT_STEPS];
      dv_v[0] <= vd_r;
      for (int j = 1; j <= DV_STEPS; j++) dv_v[j] <= dv_v[j-1];
      out_valid <= dv_v[DV_STEPS];
    end
    rt_n[0]    <= {1'b0, sum_nxt};
    rt_rem[0]  <= '0;
    rt_root[0] <= '0;
    rt_tz[0]   <= in_item.sq_z;
    for (int k = 1; k <= RT_STEPS; k++) begin
      rt_n[k]    <= rt_n_nxt[k-1];
      rt_rem[k]  <= rt_rem_nxt[k-1];
      rt_root[k] <= rt_root_nxt[k-1];
      rt_tz[k]   <= rt_tz[k-1];
    end
    d2_r  <= dmag_nxt * dmag_nxt;
    tzd_r <= rt_tz[RT_STEPS];
    dv_rem[0] <= {48'd0, thick_sq[31:16]};
    dv_den[0] <= den_nxt;
    dv_q[0]   <= '0;
    // quotient >= 2^32 exactly when num >> 32 >= den (zero den included)
    dv_sat[0] <= (den_nxt[63:16] == 48'd0) && (thick_sq[31:16] >= den_nxt[15:0]);
    for (int j = 1; j <= DV_STEPS; j++) begin
      dv_rem[j] <= dv_rem_nxt[j-1];
      dv_q[j]   <= dv_q_nxt[j-1];
      dv_den[j] <= dv_den[j-1];
      dv_sat[j] <= dv_sat[j-1];
    end
    out_field <= dv_sat[DV_STEPS] ? {tfv_pkg::FIELD_W{1'b1}} : dv_q[DV_STEPS];
    out_sat   <= dv_sat[DV_STEPS];
  end

endmodule

// ----- hw/rtl/torus_field_value.sv -----
// Torus field value: top level with configuration registers, front end,
// queue and back end. Depends on tfv_pkg, tfv_front, tfv_queue, tfv_back.
//
// One point is taken per clock cycle (start while busy is low) and its field
// value appears on out_field_value with out_valid high for one cycle, after
// passing through 3 front stages (products, rounded row sums, squares), the
// queue register, 1 sum stage, 32 square-root stages (one root bit each),
// distance square, denominator, 32 divider stages (one quotient bit each)
// and the output register. Results cannot be held off; the back end drains
// the queue every cycle, so busy stays low in operation.
module torus_field_value #(
  parameter int COORD_WIDTH = tfv_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_WIDTH-1:0]          in_pos_x,
  input  logic [COORD_WIDTH-1:0]          in_pos_y,
  input  logic [COORD_WIDTH-1:0]          in_pos_z,
  output logic                            out_valid,
  output logic [tfv_pkg::FIELD_W-1:0]     out_field_value,
  output logic                            out_saturated,
  input  logic                            cfg_we,
  input  logic [tfv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [63:0] row_x_r, row_y_r, row_z_r;
  logic [15:0] radius_r;
  logic [31:0] thick_sq_r;
  logic [15:0] min_div_r;

  logic              fr_valid;
  tfv_pkg::sq_item_t fr_item;
  tfv_pkg::sq_item_t q_item;
  tfv_pkg::q_stat_t  q_stat;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r    <= tfv_pkg::ROW_RESET;
      row_y_r    <= tfv_pkg::ROW_RESET;
      row_z_r    <= tfv_pkg::ROW_RESET;
      radius_r   <= tfv_pkg::RADIUS_RESET;
      thick_sq_r <= tfv_pkg::THICK_SQ_RESET;
      min_div_r  <= tfv_pkg::MIN_DIV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfv_pkg::REG_ROW_X:    row_x_r    <= cfg_wdata;
        tfv_pkg::REG_ROW_Y:    row_y_r    <= cfg_wdata;
        tfv_pkg::REG_ROW_Z:    row_z_r    <= cfg_wdata;
        tfv_pkg::REG_RADIUS:   radius_r   <= cfg_wdata[15:0];
        tfv_pkg::REG_THICK_SQ: thick_sq_r <= cfg_wdata[31:0];
        tfv_pkg::REG_MIN_DIV:  min_div_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  tfv_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .pos_x    ($signed(in_pos_x)),
    .pos_y    ($signed(in_pos_y)),
    .pos_z    ($signed(in_pos_z)),
    .row_x    (row_x_r),
    .row_y    (row_y_r),
    .row_z    (row_z_r),
    .out_valid(fr_valid),
    .out_item (fr_item)
  );

  tfv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_valid),
    .push_item(fr_item),
    .pop      (1'b1),
    .pop_item (q_item),
    .stat     (q_stat)
  );

  tfv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (!q_stat.empty),
    .in_item  (q_item),
    .radius   (radius_r),
    .thick_sq (thick_sq_r),
    .min_div  (min_div_r),
    .out_valid(out_valid),
    .out_field(out_field_value),
    .out_sat  (out_saturated)
  );

endmodule

// ----- hw/rtl/tfv_checker.sv -----
// Port-level checks for torus_field_value, bound to the top level.
// Depends on tfv_pkg.
module tfv_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_valid,
  input logic [tfv_pkg::FIELD_W-1:0] out_field_value,
  input logic                        out_saturated
);

  a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_field_value == {tfv_pkg::FIELD_W{1'b1}})
    else $error("saturated result not clamped");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled although back end drains every cycle");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("transfer right after reset");

endmodule

bind torus_field_value tfv_checker u_tfv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_field_value(out_field_value),
  .out_saturated  (out_saturated)
);

// ----- test/torus_field_value_tb.sv -----
// Self-checking testbench for torus_field_value: directed and random points
// over several register settings, checked against an in-bench field predictor.
// Depends on tfv_pkg and the torus_field_value RTL.
module torus_field_value_tb;
  import tfv_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int SETTLE = 90;   // longer than the pipeline depth

  typedef struct {
    logic [CW-1:0] x, y, z;
  } point_t;

  typedef struct {
    logic [FIELD_W-1:0] field;
    logic               sat;
  } field_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic [FIELD_W-1:0] out_field_value;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  torus_field_value u_dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [63:0] m_row [3];
  logic [15:0] m_radius;
  logic [31:0] m_thick;
  logic [15:0] m_mindiv;

  point_t pending_points[$];
  field_t expected_fields[$];
  int idle_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int settings_run = 0;
  logic took = 1'b0;

  function automatic longint row_value(logic [63:0] row, longint x, longint y, longint z);
    longint acc, r;
    acc = x * longint'($signed(row[15:0])) + y * longint'($signed(row[31:16])) +
          z * longint'($signed(row[47:32])) + longint'($signed(row[63:48])) * 4096;
    r = (acc + 2048) >>> 12;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483647) r = -64'sd2147483647;
    return r;
  endfunction

  function automatic logic [63:0] mag_sq(longint v);
    logic [63:0] a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n = n - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  function automatic field_t torus_field(point_t p);
    field_t f;
    longint x, y, z, tx, ty, tz, d;
    logic [63:0] den, q;
    x = longint'($signed(p.x));
    y = longint'($signed(p.y));
    z = longint'($signed(p.z));
    tx = row_value(m_row[0], x, y, z);
    ty = row_value(m_row[1], x, y, z);
    tz = row_value(m_row[2], x, y, z);
    d = longint'(floor_root(mag_sq(tx) + mag_sq(ty))) - longint'({48'd0, m_radius});
    den = add_clip(add_clip(mag_sq(d), mag_sq(tz)), {48'd0, m_mindiv});
    if (den == 0) begin
      f.field = '1;
      f.sat = 1'b1;
    end else begin
      q = {16'd0, m_thick, 16'd0} / den;
      f.sat = (q > 64'hFFFF_FFFF);
      f.field = f.sat ? '1 : q[31:0];
    end
    return f;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // transfer accepted on start && !busy; predict, then check results
  always @(posedge clk) begin
    field_t e;
    point_t p_in;
    took <= start && !busy && rst_n;
    if (rst_n && start && !busy) begin
      p_in.x = in_pos_x;
      p_in.y = in_pos_y;
      p_in.z = in_pos_z;
      expected_fields = {expected_fields, torus_field(p_in)};
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_fields.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_fields.pop_front();
        if (out_field_value !== e.field)
          report_mismatch($sformatf("field_value %h, expected %h", out_field_value, e.field));
        if (out_saturated !== e.sat)
          report_mismatch($sformatf("saturated %b, expected %b", out_saturated, e.sat));
      end
    end
  end

  // driver: change inputs on the falling edge
  always @(negedge clk) begin
    point_t p;
    if (rst_n && (!start || took)) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
        p = pending_points.pop_front();
        start <= 1'b1;
        in_pos_x <= p.x;
        in_pos_y <= p.y;
        in_pos_z <= p.z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROW_X:    m_row[0] = data;
      REG_ROW_Y:    m_row[1] = data;
      REG_ROW_Z:    m_row[2] = data;
      REG_RADIUS:   m_radius = data[15:0];
      REG_THICK_SQ: m_thick = data[31:0];
      REG_MIN_DIV:  m_mindiv = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_points.size() == 0 && !start && expected_fields.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] small_coord();
    return 16'($signed($urandom_range(4096)) - 2048);
  endfunction

  task automatic add_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points = {pending_points, p};
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      if ($urandom_range(2) == 0)
        add_point(16'($urandom()), 16'($urandom()), 16'($urandom()));
      else
        add_point(small_coord(), small_coord(), small_coord());
    end
  endtask

  // identity-like rows with a random translation keep the field in range
  function automatic logic [63:0] near_row(int axis);
    logic [63:0] r;
    r = '0;
    r[axis*16 +: 16] = 16'($urandom_range(8192) + 1024);
    r[63:48] = 16'($signed($urandom_range(1024)) - 512);
    return r;
  endfunction

  initial begin
    logic [15:0] ext [4];
    int phase;
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    m_row = '{ROW_RESET, ROW_RESET, ROW_RESET};
    m_radius = RADIUS_RESET;
    m_thick = THICK_SQ_RESET;
    m_mindiv = MIN_DIV_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values
    add_point(16'h0000, 16'h0000, 16'h0000);
    add_point(16'h7FFF, 16'h8000, 16'hFFFF);
    add_random(40);
    drain();
    settings_run++;

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 67;
        2: idle_pct = 24;
        3: idle_pct = 0;
        4: idle_pct = 67;
        5: idle_pct = 24;
        default: idle_pct = 0;
      endcase
      case (phase)
        0: begin  // unit-ish transform, large numerator: saturation near the ring
          write_reg(REG_ROW_X, 64'h0000_0000_0000_1000);
          write_reg(REG_ROW_Y, 64'h0000_0000_1000_0000);
          write_reg(REG_ROW_Z, 64'h0000_1000_0000_0000);
          write_reg(REG_RADIUS, 64'h0400);
          write_reg(REG_THICK_SQ, 64'hFFFF_FFFF);
          write_reg(REG_MIN_DIV, 64'd1);
        end
        1: begin  // all extremes of the coefficient fields
          write_reg(REG_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
          write_reg(REG_ROW_Y, 64'h8000_8000_8000_8000);
          write_reg(REG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_RADIUS, 64'hFFFF);
          write_reg(REG_THICK_SQ, 64'h0);
          write_reg(REG_MIN_DIV, 64'hFFFF);
        end
        2: begin  // over-wide data gets masked; unused index ignored
          write_reg(REG_ROW_X, near_row(0));
          write_reg(REG_ROW_Y, near_row(1));
          write_reg(REG_ROW_Z, near_row(2));
          write_reg(REG_RADIUS, rand64());
          write_reg(REG_THICK_SQ, rand64());
          write_reg(REG_MIN_DIV, rand64() | 64'h1);
          write_reg(REG_UNUSED, rand64());
          write_reg(REG_UNUSED_HI, rand64());
        end
        3: begin
          write_reg(REG_ROW_X, rand64());
          write_reg(REG_ROW_Y, rand64());
          write_reg(REG_ROW_Z, rand64());
          write_reg(REG_RADIUS, 64'd0);
          write_reg(REG_THICK_SQ, 64'h8000_0000);
          write_reg(REG_MIN_DIV, 64'd1);
        end
        default: begin
          write_reg(REG_ROW_X, ($urandom_range(1)) ? near_row(0) : rand64());
          write_reg(REG_ROW_Y, ($urandom_range(1)) ? near_row(1) : rand64());
          write_reg(REG_ROW_Z, ($urandom_range(1)) ? near_row(2) : rand64());
          write_reg(REG_RADIUS, 64'($urandom_range(16'hFFFF)));
          write_reg(REG_THICK_SQ, 64'($urandom()));
          write_reg(REG_MIN_DIV, 64'($urandom_range(16'hFFFF, 1)));
        end
      endcase
      if (phase < 2) begin
        // coordinate extremes in every axis
        for (int i = 0; i < 4; i++) begin
          add_point(ext[i], 16'h0000, 16'h0000);
          add_point(16'h0000, ext[i], 16'h0000);
          add_point(16'h0000, 16'h0000, ext[i]);
        end
        add_point(16'h0400, 16'h0000, 16'h0000);  // on the ring
      end
      add_random(55);
      drain();
      settings_run++;
    end

    $display("Covered %0d results over %0d register settings, idle 0/24/67 pct.",
             results_seen, settings_run);
    if (errors == 0) begin
      $display("torus_field_value verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("torus_field_value verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("torus_field_value verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tfv_pkg.sv
hw/rtl/tfv_front.sv
hw/rtl/tfv_queue.sv
hw/rtl/tfv_back.sv
hw/rtl/torus_field_value.sv
hw/rtl/tfv_checker.sv
test/torus_field_value_tb.sv
